// ===== design/gqm_pkg.sv =====
package gqm_pkg;

    // Default side of the square face mask.
    localparam int MASK_SIDE_DEF = 32;

    // Fixed field widths of the item ports.
    localparam int COORD_W = 5;
    localparam int SIZE_W  = 6;
    localparam int TILE_W  = 16;
    localparam int LIGHT_W = 8;
    localparam int ATTR_W  = TILE_W + LIGHT_W;

    // Opcode values.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_WR,
        S_SCAN_CHK,
        S_TILE0,
        S_W_NEXT,
        S_W_CMP,
        S_H_NEXT,
        S_H_ROW,
        S_H_CMP,
        S_CLR,
        S_CLR_WR,
        S_OUT
    } t_state;

endpackage

// ===== design/greedy_quad_mesher.sv =====
// Load: a row read, then the row written back; no result; a load outside the mask is dropped.
// Extract: scans rows down to the first visible one, compares each cell added along the row,
// reads each row tried downward and compares each cell in it, reads and writes back each
// cleared row, then loads the result register once free; all through the single read port
// of each mask memory. One transaction at a time; a waiting result does not block loads.
// Reset clears the per-row valid flags, so the mask reads empty at once; no clearing pass.
module greedy_quad_mesher #(
    parameter int MASK_SIDE = gqm_pkg::MASK_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_opcode,
    input  logic [gqm_pkg::COORD_W-1:0]  i_cell_u,
    input  logic [gqm_pkg::COORD_W-1:0]  i_cell_v,
    input  logic                         i_block_solid,
    input  logic                         i_across_solid,
    input  logic [gqm_pkg::TILE_W-1:0]   i_face_tile,
    input  logic [gqm_pkg::LIGHT_W-1:0]  i_exposed_light,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_found,
    output logic [gqm_pkg::COORD_W-1:0]  o_rect_u,
    output logic [gqm_pkg::COORD_W-1:0]  o_rect_v,
    output logic [gqm_pkg::SIZE_W-1:0]   o_rect_width,
    output logic [gqm_pkg::SIZE_W-1:0]   o_rect_height,
    output logic [gqm_pkg::TILE_W-1:0]   o_rect_tile,
    output logic [gqm_pkg::LIGHT_W-1:0]  o_rect_light
);
    import gqm_pkg::*;

    localparam int CELLS = MASK_SIDE * MASK_SIDE;
    localparam int IDX_W = $clog2(MASK_SIDE);
    localparam int CNT_W = $clog2(MASK_SIDE + 1);
    localparam int POS_W = CNT_W + 1;
    localparam int AW    = $clog2(CELLS);

    // Control state.
    t_state                r_state, n_state;
    logic [MASK_SIDE-1:0]  r_row_vld;
    logic                  r_rd_vld;
    logic                  r_out_vld;

    // Working registers.
    logic [IDX_W-1:0]      r_cu, r_cv, r_v, r_su;
    logic [IDX_W-1:0]      n_v, n_su;
    logic                  r_ld_vis;
    logic [ATTR_W-1:0]     r_ld_attr;
    logic [CNT_W-1:0]      r_w, r_h, r_k, n_w, n_h, n_k;
    logic [MASK_SIDE-1:0]  r_row, n_row;
    logic [ATTR_W-1:0]     r_attr, n_attr;
    logic                  r_found, n_found;

    // Result register.
    logic                  r_o_found;
    logic [COORD_W-1:0]    r_o_u, r_o_v;
    logic [SIZE_W-1:0]     r_o_w, r_o_h;
    logic [ATTR_W-1:0]     r_o_attr;

    // Memory ports.
    logic                  vis_we;
    logic [IDX_W-1:0]      vis_waddr, vis_raddr;
    logic [MASK_SIDE-1:0]  vis_wdata, vis_rdata;
    logic                  tl_we;
    logic [AW-1:0]         tl_waddr, tl_raddr;
    logic [ATTR_W-1:0]     tl_wdata, tl_rdata;

    // Derived values.
    logic                  in_acc, in_range, out_load;
    logic [MASK_SIDE-1:0]  row_eff, seg_mask, ld_bit;
    logic [IDX_W-1:0]      first_u;
    logic [POS_W-1:0]      w_pos, h_row, clr_row, k_next, k_col;

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] u,
                                                input logic [IDX_W-1:0] v);
        cell_addr = AW'(AW'(v) * AW'(MASK_SIDE) + AW'(u));
    endfunction

    // Visibility memory: one row of the mask per entry.
    gqm_ram #(
        .WIDTH (MASK_SIDE),
        .DEPTH (MASK_SIDE)
    ) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rdata)
    );

    // Tile and light memory: one entry per cell, written only by visible loads.
    gqm_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (CELLS)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (tl_we),
        .i_waddr (tl_waddr),
        .i_wdata (tl_wdata),
        .i_raddr (tl_raddr),
        .o_rdata (tl_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_cell_u) < MASK_SIDE) && (32'(i_cell_v) < MASK_SIDE);
    assign out_load   = (r_state == S_OUT) && (!r_out_vld || i_out_ready);

    // A row that was never written reads as all hidden.
    assign row_eff = r_rd_vld ? vis_rdata : '0;

    // Positions relative to the rectangle under construction.
    assign w_pos   = POS_W'(r_su) + POS_W'(r_w);
    assign h_row   = POS_W'(r_v) + POS_W'(r_h);
    assign clr_row = POS_W'(r_v) + POS_W'(r_k);
    assign k_next  = POS_W'(r_k) + POS_W'(1);
    assign k_col   = POS_W'(r_su) + k_next;
    assign ld_bit  = MASK_SIDE'(1) << r_cu;

    // Column span of the rectangle.
    always_comb begin
        for (int j = 0; j < MASK_SIDE; j++) begin
            seg_mask[j] = (POS_W'(j) >= POS_W'(r_su)) && (POS_W'(j) < w_pos);
        end
    end

    // Lowest visible column in the row just read.
    always_comb begin
        first_u = '0;
        for (int j = MASK_SIDE - 1; j >= 0; j--) begin
            if (row_eff[j]) begin
                first_u = IDX_W'(j);
            end
        end
    end

    // Sequencer: next state, memory accesses and working register updates.
    always_comb begin
        n_state   = r_state;
        n_v       = r_v;
        n_su      = r_su;
        n_w       = r_w;
        n_h       = r_h;
        n_k       = r_k;
        n_row     = r_row;
        n_attr    = r_attr;
        n_found   = r_found;
        vis_we    = 1'b0;
        vis_waddr = r_cv;
        vis_wdata = row_eff;
        vis_raddr = '0;
        tl_we     = 1'b0;
        tl_waddr  = cell_addr(r_cu, r_cv);
        tl_wdata  = r_ld_attr;
        tl_raddr  = cell_addr(r_su, r_v);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_EXTRACT) begin
                        vis_raddr = '0;
                        n_v       = '0;
                        n_state   = S_SCAN_CHK;
                    end else if (in_range) begin
                        vis_raddr = IDX_W'(i_cell_v);
                        n_state   = S_LD_WR;
                    end
                end
            end
            S_LD_WR: begin
                vis_we    = 1'b1;
                vis_waddr = r_cv;
                vis_wdata = r_ld_vis ? (row_eff | ld_bit) : (row_eff & ~ld_bit);
                tl_we     = r_ld_vis;
                n_state   = S_IDLE;
            end
            S_SCAN_CHK: begin
                if (row_eff != '0) begin
                    n_su     = first_u;
                    n_row    = row_eff;
                    n_found  = 1'b1;
                    tl_raddr = cell_addr(first_u, r_v);
                    n_state  = S_TILE0;
                end else if (r_v == IDX_W'(MASK_SIDE - 1)) begin
                    n_found = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_v       = r_v + IDX_W'(1);
                    vis_raddr = r_v + IDX_W'(1);
                end
            end
            S_TILE0: begin
                n_attr  = tl_rdata;
                n_w     = CNT_W'(1);
                n_state = S_W_NEXT;
            end
            S_W_NEXT: begin
                if ((w_pos < POS_W'(MASK_SIDE)) && r_row[w_pos[IDX_W-1:0]]) begin
                    tl_raddr = cell_addr(w_pos[IDX_W-1:0], r_v);
                    n_state  = S_W_CMP;
                end else begin
                    n_h     = CNT_W'(1);
                    n_state = S_H_NEXT;
                end
            end
            S_W_CMP: begin
                if (tl_rdata == r_attr) begin
                    n_w     = r_w + CNT_W'(1);
                    n_state = S_W_NEXT;
                end else begin
                    n_h     = CNT_W'(1);
                    n_state = S_H_NEXT;
                end
            end
            S_H_NEXT: begin
                if (h_row < POS_W'(MASK_SIDE)) begin
                    vis_raddr = h_row[IDX_W-1:0];
                    n_state   = S_H_ROW;
                end else begin
                    n_k     = '0;
                    n_state = S_CLR;
                end
            end
            S_H_ROW: begin
                n_k = '0;
                if ((row_eff & seg_mask) == seg_mask) begin
                    tl_raddr = cell_addr(r_su, h_row[IDX_W-1:0]);
                    n_state  = S_H_CMP;
                end else begin
                    n_state = S_CLR;
                end
            end
            S_H_CMP: begin
                if (tl_rdata != r_attr) begin
                    n_k     = '0;
                    n_state = S_CLR;
                end else if (k_next < POS_W'(r_w)) begin
                    n_k      = k_next[CNT_W-1:0];
                    tl_raddr = cell_addr(k_col[IDX_W-1:0], h_row[IDX_W-1:0]);
                end else begin
                    n_h     = r_h + CNT_W'(1);
                    n_state = S_H_NEXT;
                end
            end
            S_CLR: begin
                if (r_k < r_h) begin
                    vis_raddr = clr_row[IDX_W-1:0];
                    n_state   = S_CLR_WR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CLR_WR: begin
                vis_we    = 1'b1;
                vis_waddr = clr_row[IDX_W-1:0];
                vis_wdata = row_eff & ~seg_mask;
                n_k       = r_k + CNT_W'(1);
                n_state   = S_CLR;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (32'(vis_raddr) < MASK_SIDE) ? r_row_vld[vis_raddr] : 1'b0;
            if (vis_we) begin
                r_row_vld[vis_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cu      <= IDX_W'(i_cell_u);
            r_cv      <= IDX_W'(i_cell_v);
            r_ld_vis  <= i_block_solid && !i_across_solid;
            r_ld_attr <= {i_face_tile, i_exposed_light};
        end
        r_v     <= n_v;
        r_su    <= n_su;
        r_w     <= n_w;
        r_h     <= n_h;
        r_k     <= n_k;
        r_row   <= n_row;
        r_attr  <= n_attr;
        r_found <= n_found;
        if (out_load) begin
            r_o_found <= r_found;
            r_o_u     <= r_found ? COORD_W'(r_su) : '0;
            r_o_v     <= r_found ? COORD_W'(r_v) : '0;
            r_o_w     <= r_found ? SIZE_W'(r_w) : '0;
            r_o_h     <= r_found ? SIZE_W'(r_h) : '0;
            r_o_attr  <= r_found ? r_attr : '0;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_found       = r_o_found;
    assign o_rect_u      = r_o_u;
    assign o_rect_v      = r_o_v;
    assign o_rect_width  = r_o_w;
    assign o_rect_height = r_o_h;
    assign o_rect_tile   = r_o_attr[ATTR_W-1:LIGHT_W];
    assign o_rect_light  = r_o_attr[LIGHT_W-1:0];

    // An extract transaction always starts with the row scan.
    a_extract_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_opcode == OP_EXTRACT)) |=> (r_state == S_SCAN_CHK))
        else $error("extract did not start the row scan");

    // A finished rectangle has a nonzero size and lies inside the mask.
    a_rect_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_found) |->
            ((r_w != '0) && (r_h != '0) && (w_pos <= POS_W'(MASK_SIDE))
             && (h_row <= POS_W'(MASK_SIDE))))
        else $error("rectangle empty or outside the mask");

    // A not-found result carries no rectangle.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_o_found) |->
            ((r_o_w == '0) && (r_o_h == '0) && (r_o_attr == '0)))
        else $error("not-found result carries a rectangle");

endmodule

// ===== design/gqm_ram.sv =====
module gqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gqm_pkg::*;

    localparam int     SIDE         = MASK_SIDE_DEF;
    localparam int     CELLS        = SIDE * SIDE;
    localparam int     RANDOM_ITEMS = 1560;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     HOLD_CYCLES  = 800;
    localparam longint CYCLE_LIMIT  = 20_000_000;

    // One input transaction as the sender sees it.
    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic               solid;
        logic               across;
        logic [TILE_W-1:0]  tile;
        logic [LIGHT_W-1:0] light;
    } t_mesh_item;

    // One merged rectangle as the block returns it.
    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [TILE_W-1:0]  tile;
        logic [LIGHT_W-1:0] light;
    } t_quad;

    // Clock, reset and the signals the testbench drives.
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_op      = OP_LOAD;
    logic [COORD_W-1:0] in_u       = '0;
    logic [COORD_W-1:0] in_v       = '0;
    logic               in_solid   = 1'b0;
    logic               in_across  = 1'b0;
    logic [TILE_W-1:0]  in_tile    = '0;
    logic [LIGHT_W-1:0] in_light   = '0;
    logic               out_ready  = 1'b0;

    // Signals the block drives.
    logic               in_ready;
    logic               out_valid;
    logic               out_found;
    logic [COORD_W-1:0] out_u;
    logic [COORD_W-1:0] out_v;
    logic [SIZE_W-1:0]  out_width;
    logic [SIZE_W-1:0]  out_height;
    logic [TILE_W-1:0]  out_tile;
    logic [LIGHT_W-1:0] out_light;

    // Shadow copy of the face mask kept by the predictor.
    bit                 mask_vis   [CELLS];
    logic [TILE_W-1:0]  mask_tile  [CELLS];
    logic [LIGHT_W-1:0] mask_light [CELLS];

    t_quad              expected_quads[$];
    logic [TILE_W-1:0]  pal_tile  [3];
    logic [LIGHT_W-1:0] pal_light [3];

    int     items_sent   = 0;
    int     quads_found  = 0;
    int     quads_empty  = 0;
    int     errors       = 0;
    int     burst_left   = 0;
    int     gap_max      = 0;
    bit     last_found   = 1'b0;
    longint cycle_count  = 0;

    // Long receiver hold-off, requested by a test and counted by the receiver.
    int     hold_req_id  = 0;
    int     hold_req_len = 0;
    int     hold_seen    = 0;
    int     hold_left    = 0;
    int     mode_left    = 0;
    int     stall_pct    = 0;

    greedy_quad_mesher u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_opcode       (in_op),
        .i_cell_u       (in_u),
        .i_cell_v       (in_v),
        .i_block_solid  (in_solid),
        .i_across_solid (in_across),
        .i_face_tile    (in_tile),
        .i_exposed_light(in_light),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_found        (out_found),
        .o_rect_u       (out_u),
        .o_rect_v       (out_v),
        .o_rect_width   (out_width),
        .o_rect_height  (out_height),
        .o_rect_tile    (out_tile),
        .o_rect_light   (out_light)
    );

    // Free-running clock.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a run that hangs ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d rectangles outstanding.",
                     cycle_count, expected_quads.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Predictor: a load writes one cell of the shadow mask.
    task automatic mesh_load(input t_mesh_item it);
        int idx;
        if (int'(it.u) < SIDE && int'(it.v) < SIDE) begin
            idx = int'(it.u) + int'(it.v) * SIDE;
            if (it.solid && !it.across) begin
                mask_vis[idx]   = 1'b1;
                mask_tile[idx]  = it.tile;
                mask_light[idx] = it.light;
            end else begin
                // A hidden face only drops visibility; tile and light stay.
                mask_vis[idx] = 1'b0;
            end
        end
    endtask

    function automatic bit cell_matches(input int u, input int v,
                                        input logic [TILE_W-1:0] t,
                                        input logic [LIGHT_W-1:0] l);
        int idx;
        idx = u + v * SIDE;
        return mask_vis[idx] && mask_tile[idx] == t && mask_light[idx] == l;
    endfunction

    // Predictor: find, grow and clear the next rectangle of the shadow mask.
    function automatic t_quad mesh_extract();
        t_quad              q;
        int                 su, sv, w, h, u, v, k;
        bit                 hit, row_ok;
        logic [TILE_W-1:0]  t;
        logic [LIGHT_W-1:0] l;
        q   = '0;
        hit = 1'b0;
        su  = 0;
        sv  = 0;
        for (v = 0; v < SIDE && !hit; v++)
            for (u = 0; u < SIDE && !hit; u++)
                if (mask_vis[u + v * SIDE]) begin
                    su  = u;
                    sv  = v;
                    hit = 1'b1;
                end
        if (!hit)
            return q;
        t = mask_tile[su + sv * SIDE];
        l = mask_light[su + sv * SIDE];
        // Widen along the row, then grow downward by whole rows.
        w = 1;
        while (su + w < SIDE && cell_matches(su + w, sv, t, l))
            w++;
        h      = 1;
        row_ok = 1'b1;
        while (sv + h < SIDE && row_ok) begin
            for (k = 0; k < w && row_ok; k++)
                row_ok = cell_matches(su + k, sv + h, t, l);
            if (row_ok)
                h++;
        end
        for (v = 0; v < h; v++)
            for (u = 0; u < w; u++)
                mask_vis[(su + u) + (sv + v) * SIDE] = 1'b0;
        q.found  = 1'b1;
        q.u      = COORD_W'(su);
        q.v      = COORD_W'(sv);
        q.width  = SIZE_W'(w);
        q.height = SIZE_W'(h);
        q.tile   = t;
        q.light  = l;
        return q;
    endfunction

    function automatic t_mesh_item mk_load(input int u, input int v, input bit solid,
                                           input bit across, input logic [TILE_W-1:0] t,
                                           input logic [LIGHT_W-1:0] l);
        t_mesh_item it;
        it.op     = OP_LOAD;
        it.u      = COORD_W'(u);
        it.v      = COORD_W'(v);
        it.solid  = solid;
        it.across = across;
        it.tile   = t;
        it.light  = l;
        return it;
    endfunction

    // Extract transactions carry random content in the unused fields.
    function automatic t_mesh_item mk_extract();
        t_mesh_item it;
        it    = t_mesh_item'({$urandom, $urandom});
        it.op = OP_EXTRACT;
        return it;
    endfunction

    // Random transaction of any kind, mostly loads with random visibility.
    function automatic t_mesh_item noise_item();
        t_mesh_item it;
        it    = t_mesh_item'({$urandom, $urandom});
        it.op = ($urandom_range(99, 0) < 15) ? OP_EXTRACT : OP_LOAD;
        return it;
    endfunction

    // Offer one transaction and wait for it to be accepted; valid stays high.
    task automatic send_item(input t_mesh_item it);
        t_quad q;
        in_valid  <= 1'b1;
        in_op     <= it.op;
        in_u      <= it.u;
        in_v      <= it.v;
        in_solid  <= it.solid;
        in_across <= it.across;
        in_tile   <= it.tile;
        in_light  <= it.light;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (it.op == OP_EXTRACT) begin
            q          = mesh_extract();
            last_found = q.found;
            expected_quads.insert(expected_quads.size(), q);
        end else begin
            mesh_load(it);
        end
    endtask

    // The sender works in bursts with random gaps between them.
    task automatic send_paced(input t_mesh_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_item(it);
    endtask

    // Extract until the mask reports that nothing visible is left.
    task automatic extract_all();
        do
            send_paced(mk_extract());
        while (last_found);
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_quads.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_palette();
        pal_tile[0]  = TILE_W'($urandom);
        pal_light[0] = LIGHT_W'($urandom);
        // The second color differs from the first in either tile or light only.
        if ($urandom_range(1, 0)) begin
            pal_tile[1]  = pal_tile[0];
            pal_light[1] = pal_light[0] ^ (8'd1 << $urandom_range(7, 0));
        end else begin
            pal_tile[1]  = TILE_W'($urandom);
            pal_light[1] = pal_light[0];
        end
        pal_tile[2]  = TILE_W'($urandom);
        pal_light[2] = LIGHT_W'($urandom);
    endtask

    // Load a small mostly uniform patch, with stray colors and noise inside.
    task automatic load_patch();
        int u0, v0, w, h, c, p, du, dv;
        u0 = $urandom_range(SIDE - 1, 0);
        v0 = $urandom_range(SIDE - 1, 0);
        w  = $urandom_range(8, 1);
        h  = $urandom_range(6, 1);
        if (u0 + w > SIDE)
            w = SIDE - u0;
        if (v0 + h > SIDE)
            h = SIDE - v0;
        c = $urandom_range(2, 0);
        for (dv = 0; dv < h; dv++)
            for (du = 0; du < w; du++) begin
                p = ($urandom_range(99, 0) < 85) ? c : $urandom_range(2, 0);
                send_paced(mk_load(u0 + du, v0 + dv, 1'b1, 1'b0, pal_tile[p], pal_light[p]));
                if ($urandom_range(99, 0) < 3)
                    send_paced(noise_item());
            end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Compare one accepted rectangle with the oldest prediction.
    task automatic check_quad();
        t_quad want;
        if (expected_quads.size() == 0) begin
            $error("rectangle returned with no extract outstanding");
            errors++;
        end else begin
            want = expected_quads.pop_front();
            check_field("found", 32'(want.found), 32'(out_found));
            check_field("rect_u", 32'(want.u), 32'(out_u));
            check_field("rect_v", 32'(want.v), 32'(out_v));
            check_field("rect_width", 32'(want.width), 32'(out_width));
            check_field("rect_height", 32'(want.height), 32'(out_height));
            check_field("rect_tile", 32'(want.tile), 32'(out_tile));
            check_field("rect_light", 32'(want.light), 32'(out_light));
            if (want.found)
                quads_found++;
            else
                quads_empty++;
        end
    endtask

    // Receiver: checks each transaction and stalls on a pattern of its own.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready)
                check_quad();
            if (hold_seen != hold_req_id) begin
                hold_seen <= hold_req_id;
                hold_left <= hold_req_len;
                out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                // Switch stall density now and then, including stretches with none.
                if (mode_left == 0) begin
                    mode_left <= $urandom_range(300, 40);
                    case ($urandom_range(3, 0))
                        0:       stall_pct <= 0;
                        1:       stall_pct <= 25;
                        2:       stall_pct <= 50;
                        default: stall_pct <= 90;
                    endcase
                end else begin
                    mode_left <= mode_left - 1;
                end
                out_ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // Edge cells, tile and light extremes, hidden loads and merging in both directions.
    task automatic test_directed();
        gap_max = 3;
        send_paced(mk_extract());
        send_paced(mk_load(0, 0, 1'b1, 1'b0, 16'hFFFF, 8'hFF));
        send_paced(mk_load(1, 0, 1'b1, 1'b0, 16'hFFFF, 8'hFF));
        send_paced(mk_load(31, 31, 1'b1, 1'b0, 16'h0000, 8'h00));
        send_paced(mk_load(30, 31, 1'b1, 1'b0, 16'h0000, 8'h01));
        send_paced(mk_load(5, 3, 1'b0, 1'b0, 16'hAAAA, 8'h55));
        send_paced(mk_load(6, 3, 1'b1, 1'b1, 16'h5555, 8'hAA));
        send_paced(mk_load(7, 3, 1'b0, 1'b1, 16'h1234, 8'h56));
        // A visible cell hidden again keeps its old tile but must not show up.
        send_paced(mk_load(8, 3, 1'b1, 1'b0, 16'h1234, 8'h56));
        send_paced(mk_load(8, 3, 1'b0, 1'b0, 16'h4321, 8'h65));
        send_paced(mk_load(0, 1, 1'b1, 1'b0, 16'hFFFF, 8'hFF));
        send_paced(mk_load(1, 1, 1'b1, 1'b0, 16'hFFFF, 8'hFF));
        send_paced(mk_load(2, 1, 1'b1, 1'b0, 16'hFFFF, 8'hFF));
        extract_all();
    endtask

    // A full row and a full column give the largest width and height.
    task automatic test_full_extent();
        int k;
        gap_max = 2;
        pick_palette();
        for (k = 0; k < SIDE; k++)
            send_paced(mk_load(k, SIDE - 1, 1'b1, 1'b0, pal_tile[0], pal_light[0]));
        extract_all();
        for (k = 0; k < SIDE; k++)
            send_paced(mk_load(SIDE - 1, k, 1'b1, 1'b0, pal_tile[2], pal_light[2]));
        extract_all();
    endtask

    // The receiver holds off while extracts keep coming, so the input stalls.
    task automatic test_backpressure();
        gap_max = 0;
        pick_palette();
        repeat (3) load_patch();
        hold_req_len <= HOLD_CYCLES;
        hold_req_id  <= hold_req_id + 1;
        extract_all();
        repeat (4) send_paced(mk_extract());
        repeat (4) send_paced(noise_item());
        extract_all();
    endtask

    // The sender pauses until every rectangle has come back, then carries on.
    task automatic test_drain_pause();
        gap_max = 6;
        pick_palette();
        repeat (2) load_patch();
        extract_all();
        wait_for_replies();
        pick_palette();
        load_patch();
        extract_all();
    endtask

    // Random slices: patches of a few colors, noise, then extraction until empty.
    task automatic test_random_slices();
        int n;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(3, 0))
                0:       gap_max = 0;
                1:       gap_max = 2;
                2:       gap_max = 6;
                default: gap_max = 15;
            endcase
            pick_palette();
            n = $urandom_range(3, 1);
            repeat (n) load_patch();
            repeat ($urandom_range(4, 0)) send_paced(noise_item());
            extract_all();
            if ($urandom_range(9, 0) == 0)
                wait_for_replies();
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_extent();
        test_backpressure();
        test_drain_pause();
        test_random_slices();
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d load and extract transactions over directed, full-extent,",
                 items_sent);
        $display("back-pressure, drain and random slice tests; checked %0d rectangles, %0d empty.",
                 quads_found, quads_empty);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
